>>> sv/bapr_pkg.sv
// Shared types and constants for the block-ack PN replay check unit.
// Holds field widths, action and reason codes, register indexes and slot math.
// No dependencies.
`default_nettype none

package bapr_pkg;

	// Field widths fixed by the frame format
	localparam int ACTION_W = 2;
	localparam int TID_W    = 3;
	localparam int SN_W     = 12;
	localparam int RSC_W    = 64;
	localparam int PN_W     = 48;
	localparam int REASON_W = 2;
	localparam int CNT_W    = 32;

	// Reorder window and TID table
	localparam int WINDOW_SIZE = 64;
	localparam int NUM_TIDS    = 8;
	localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

	// Slot = sn mod WINDOW_SIZE, via reciprocal multiply; exact for all 12-bit SNs
	localparam int SLOT_RECIP_SHIFT = 19;
	localparam int SLOT_RECIP       = ((1 << SLOT_RECIP_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
	localparam int SLOT_RECIP_W     = $clog2(SLOT_RECIP + 1);
	localparam int SLOT_PROD_W      = SN_W + SLOT_RECIP_W;

	// Half of the 12-bit SN space
	localparam logic [SN_W-1:0] SN_HALF_RANGE = SN_W'(2048);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int OPTION_W = 2;

	localparam logic REG_CHECK_ENABLE = 1'b0;
	localparam logic REG_CHECK_OPTION = 1'b1;

	localparam logic [OPTION_W-1:0] OPT_ONE = 2'd1;
	localparam logic [OPTION_W-1:0] OPT_TWO = 2'd2;
	localparam logic [OPTION_W-1:0] OPT_RESET = OPT_ONE;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CHECK   = 2'd0,
		ACT_STORE   = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_NONE   = 2'd0,
		REASON_OLD    = 2'd1,
		REASON_REPLAY = 2'd2
	} reason_t;

	// Build the 48-bit PN from RSC bytes 7,6,5,4,1,0
	function automatic logic [PN_W-1:0] pn_of(input logic [RSC_W-1:0] rsc);
		return {rsc[63:32], rsc[15:0]};
	endfunction

endpackage

`default_nettype wire

>>> sv/block_ack_pn_replay_check_unit.sv
// Top level of the block-ack PN replay check unit: per-TID PN table, sent maps,
// drop counters, APB-style configuration registers and the transaction handshake.
// Depends on bapr_pkg.
`default_nettype none

// Per-TID 48-bit packet-number replay filter for block-ack reordering. Each input
// transaction carries one action: check a frame, store a PN, clear every stored PN,
// or release one window slot of a TID's sent map. Every transaction produces exactly
// one result transaction with drop, drop_reason and the block-wide old and replay
// drop counters as they stand after that transaction. The input transaction is held
// in one input register; the PN compare and sent-map lookup are combinational between
// that register and the result register, and the table update is registered with the
// result, so a new transaction is taken every cycle while the result side keeps up:
// sustained rate is one transaction per clock unless the result side stalls. The
// state update of a transaction lands at the same edge its result is registered, so
// the next transaction always sees it. A stalled result register stalls the input
// register, and input ready drops only when both are full. Configuration registers
// (check_enable at 0x0, check_option at 0x4) are written with an APB setup and
// access cycle and must only be changed while the unit is idle. After reset checking
// is disabled, option one is selected, all stored PNs, sent maps and counters are zero.
module block_ack_pn_replay_check_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [bapr_pkg::PADDR_W-1:0]        paddr,
	input  wire  [bapr_pkg::PDATA_W-1:0]        pwdata,
	output logic [bapr_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	// input channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [bapr_pkg::ACTION_W-1:0]       action,
	input  wire  [bapr_pkg::TID_W-1:0]          tid,
	input  wire  [bapr_pkg::SN_W-1:0]           seq_number,
	input  wire  [bapr_pkg::RSC_W-1:0]          key_rsc,
	input  wire                                 ciphered,
	input  wire                                 old_sn_flag,
	input  wire                                 old_tdls_flag,
	input  wire  [bapr_pkg::SN_W-1:0]           highest_seen_sn,
	// result channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                drop,
	output logic [bapr_pkg::REASON_W-1:0]       drop_reason,
	output logic [bapr_pkg::CNT_W-1:0]          old_drop_count,
	output logic [bapr_pkg::CNT_W-1:0]          replay_drop_count
);
	import bapr_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic                check_enable_q;
	logic [OPTION_W-1:0] check_option_q;
	logic                cfg_wr;
	logic                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	// A write completes in the access phase; pready is tied high
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b0;
			check_option_q <= OPT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CHECK_ENABLE: check_enable_q <= pwdata[0];
				REG_CHECK_OPTION: check_option_q <= pwdata[OPTION_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHECK_ENABLE: prdata = PDATA_W'(check_enable_q);
			REG_CHECK_OPTION: prdata = PDATA_W'(check_option_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic                 valid_s1;
	action_t              action_s1;
	logic [TID_W-1:0]     tid_s1;
	logic [SN_W-1:0]      sn_s1;
	logic [PN_W-1:0]      pn_s1;
	logic                 ciph_s1;
	logic                 old_sn_s1;
	logic                 old_tdls_s1;
	logic [SN_W-1:0]      highest_s1;
	logic [SN_W-1:0]      slot_quot_s1;

	logic                 out_valid_q;
	logic                 advance;
	logic                 in_accept;
	logic [SLOT_PROD_W-1:0] slot_prod;

	// Advance stage 1 into the result register when the result side has room
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	// Quotient of sn / WINDOW_SIZE, taken ahead of the input register
	assign slot_prod = SLOT_PROD_W'(seq_number) * SLOT_PROD_W'(SLOT_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1    <= action_t'(action);
			tid_s1       <= tid;
			sn_s1        <= seq_number;
			pn_s1        <= pn_of(key_rsc);
			ciph_s1      <= ciphered;
			old_sn_s1    <= old_sn_flag;
			old_tdls_s1  <= old_tdls_flag;
			highest_s1   <= highest_seen_sn;
			slot_quot_s1 <= SN_W'(slot_prod >> SLOT_RECIP_SHIFT);
		end
	end

	// ---------------------------------------------------------------
	// Per-TID state and drop counters
	// ---------------------------------------------------------------
	logic [PN_W-1:0]        last_pn_q  [NUM_TIDS];
	logic [WINDOW_SIZE-1:0] sent_map_q [NUM_TIDS];
	logic [CNT_W-1:0]       old_cnt_q;
	logic [CNT_W-1:0]       replay_cnt_q;

	// ---------------------------------------------------------------
	// Decision logic
	// ---------------------------------------------------------------
	logic [PN_W-1:0]        stored_pn;
	logic [SN_W-1:0]        quot_times_w;
	logic [SLOT_W-1:0]      slot;
	logic [WINDOW_SIZE-1:0] slot_mask;
	logic                   slot_sent;
	logic                   pn_above;
	logic                   pn_below;
	logic                   sn_higher;
	logic                   checking;
	logic [SN_W-1:0]        sn_dist;

	reason_t reason;
	logic    store_pn;
	logic    mark_sent;
	logic    clear_all;
	logic    release_slot;

	assign stored_pn    = last_pn_q[tid_s1];
	assign quot_times_w = slot_quot_s1 * SN_W'(WINDOW_SIZE);
	assign slot         = SLOT_W'(sn_s1 - quot_times_w);
	assign slot_mask    = WINDOW_SIZE'(1) << slot;
	assign slot_sent    = |(sent_map_q[tid_s1] & slot_mask);
	assign pn_above     = pn_s1 > stored_pn;
	assign pn_below     = pn_s1 < stored_pn;
	// Highest seen SN lies behind this SN when their modulo-4096 distance wraps past half
	assign sn_dist      = highest_s1 - sn_s1;
	assign sn_higher    = sn_dist > SN_HALF_RANGE;
	// Unciphered and old TDLS frames bypass the filter
	assign checking     = check_enable_q && ciph_s1 && !old_tdls_s1;

	always_comb begin
		reason       = REASON_NONE;
		store_pn     = 1'b0;
		mark_sent    = 1'b0;
		clear_all    = 1'b0;
		release_slot = 1'b0;
		unique case (action_s1)
			ACT_CHECK: begin
				if (checking) begin
					case (check_option_q)
						OPT_ONE: begin
							if (old_sn_s1) begin
								reason = REASON_OLD;
							end else if (!pn_above) begin
								reason = REASON_REPLAY;
							end else begin
								store_pn = 1'b1;
							end
						end
						OPT_TWO: begin
							if (!old_sn_s1) begin
								if (!pn_above) begin
									reason = REASON_REPLAY;
								end else begin
									store_pn  = 1'b1;
									mark_sent = 1'b1;
								end
							end else if (slot_sent) begin
								reason = REASON_OLD;
							end else if (sn_higher ? !pn_above : !pn_below) begin
								reason = REASON_REPLAY;
							end else begin
								mark_sent = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ACT_STORE:   store_pn     = check_enable_q && ciph_s1;
			ACT_CLEAR:   clear_all    = 1'b1;
			ACT_RELEASE: release_slot = 1'b1;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// State update, lands with the result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIDS; i++) begin
				last_pn_q[i]  <= '0;
				sent_map_q[i] <= '0;
			end
			old_cnt_q    <= '0;
			replay_cnt_q <= '0;
		end else if (advance) begin
			if (clear_all) begin
				for (int i = 0; i < NUM_TIDS; i++) begin
					last_pn_q[i] <= '0;
				end
			end else if (store_pn) begin
				last_pn_q[tid_s1] <= pn_s1;
			end
			if (mark_sent) begin
				sent_map_q[tid_s1] <= sent_map_q[tid_s1] | slot_mask;
			end else if (release_slot) begin
				sent_map_q[tid_s1] <= sent_map_q[tid_s1] & ~slot_mask;
			end
			// Counters wrap at 32 bits
			if (reason == REASON_OLD) begin
				old_cnt_q <= old_cnt_q + CNT_W'(1);
			end
			if (reason == REASON_REPLAY) begin
				replay_cnt_q <= replay_cnt_q + CNT_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	reason_t reason_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			reason_q <= reason;
		end
	end

	assign out_valid         = out_valid_q;
	assign drop              = (reason_q != REASON_NONE);
	assign drop_reason       = reason_q;
	// Counters only move when a new result loads, so they track the held result
	assign old_drop_count    = old_cnt_q;
	assign replay_drop_count = replay_cnt_q;

`ifndef ASSERT_OFF
	a_old_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reason == REASON_OLD |=> old_cnt_q == $past(old_cnt_q) + CNT_W'(1))
		else $error("old drop counter did not advance by one");

	a_replay_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reason == REASON_REPLAY
		|=> replay_cnt_q == $past(replay_cnt_q) + CNT_W'(1))
		else $error("replay drop counter did not advance by one");

	a_non_check_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 != ACT_CHECK |=> $stable(old_cnt_q) && $stable(replay_cnt_q))
		else $error("drop counter moved on a non-check action");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_CLEAR |=> last_pn_q[$past(tid_s1)] == '0)
		else $error("stored PN survived a clear");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire

>>> sim/tb_block_ack_pn_replay_check_unit.sv
// Self-checking testbench for block_ack_pn_replay_check_unit: directed and random frames.
// Holds its own PN tables and sent maps and compares every verdict; depends on bapr_pkg.
`default_nettype none

module tb_block_ack_pn_replay_check_unit;
	import bapr_pkg::*;

	// Option codes that let every frame through
	localparam logic [OPTION_W-1:0] OPT_PASS_LOW  = 2'd0;
	localparam logic [OPTION_W-1:0] OPT_PASS_HIGH = 2'd3;

	localparam logic [PADDR_W-1:0] ADDR_ENABLE = {REG_CHECK_ENABLE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_OPTION = {REG_CHECK_OPTION, 2'b00};

	localparam logic [PN_W-1:0] PN_MAX = '1;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 95;
	localparam int MAX_GAP       = 12;

	typedef struct {
		action_t         act;
		logic [TID_W-1:0] tid;
		logic [SN_W-1:0]  sn;
		logic [RSC_W-1:0] rsc;
		logic             ciph;
		logic             old_sn;
		logic             old_tdls;
		logic [SN_W-1:0]  highest;
	} frame_t;

	typedef struct {
		logic             drop;
		reason_t          reason;
		logic [CNT_W-1:0] old_cnt;
		logic [CNT_W-1:0] replay_cnt;
	} verdict_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [ACTION_W-1:0] action;
	logic [TID_W-1:0]    tid;
	logic [SN_W-1:0]     seq_number;
	logic [RSC_W-1:0]    key_rsc;
	logic                ciphered;
	logic                old_sn_flag;
	logic                old_tdls_flag;
	logic [SN_W-1:0]     highest_seen_sn;
	logic                out_valid;
	logic                out_ready;
	logic                drop;
	logic [REASON_W-1:0] drop_reason;
	logic [CNT_W-1:0]    old_drop_count;
	logic [CNT_W-1:0]    replay_drop_count;

	// Predicted block state and configuration
	logic [PN_W-1:0]        pn_table [NUM_TIDS];
	logic [WINDOW_SIZE-1:0] sent_table [NUM_TIDS];
	logic [CNT_W-1:0]       old_drops;
	logic [CNT_W-1:0]       replay_drops;
	logic                   cfg_enable;
	logic [OPTION_W-1:0]    cfg_option;

	verdict_t expected_verdicts [$];
	int       mismatches;
	int       verdicts_seen;
	bit       tx_gaps_on;
	bit       rx_gaps_on;

	block_ack_pn_replay_check_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs on either channel
	initial begin
		#5000000;
		$display("block_ack_pn_replay_check_unit regression: fail");
		$finish;
	end

	// Advance the predicted state by one transaction and return its verdict
	function automatic verdict_t pn_filter_step(frame_t f);
		verdict_t               v;
		logic [PN_W-1:0]        pn;
		logic [PN_W-1:0]        stored;
		logic [WINDOW_SIZE-1:0] slot_mask;
		logic [SN_W-1:0]        sn_gap;
		logic                   bad;
		reason_t                why;

		why = REASON_NONE;
		pn = {f.rsc[63:56], f.rsc[55:48], f.rsc[47:40], f.rsc[39:32], f.rsc[15:8], f.rsc[7:0]};
		stored = pn_table[f.tid];
		slot_mask = '0;
		slot_mask[f.sn % WINDOW_SIZE] = 1'b1;
		case (f.act)
			ACT_CHECK: begin
				if (cfg_enable && f.ciph && !f.old_tdls) begin
					if (cfg_option == OPT_ONE) begin
						if (f.old_sn)
							why = REASON_OLD;
						else if (pn <= stored)
							why = REASON_REPLAY;
						else
							pn_table[f.tid] = pn;
					end else if (cfg_option == OPT_TWO) begin
						if (!f.old_sn) begin
							if (pn <= stored) begin
								why = REASON_REPLAY;
							end else begin
								pn_table[f.tid] = pn;
								sent_table[f.tid] |= slot_mask;
							end
						end else if (|(sent_table[f.tid] & slot_mask)) begin
							why = REASON_OLD;
						end else begin
							// SN ahead of the highest seen: PN must climb, else it must fall
							sn_gap = f.highest - f.sn;
							bad = (sn_gap > SN_HALF_RANGE) ? (pn <= stored) : (pn >= stored);
							if (bad)
								why = REASON_REPLAY;
							else
								sent_table[f.tid] |= slot_mask;
						end
					end
				end
				if (why == REASON_OLD)
					old_drops++;
				else if (why == REASON_REPLAY)
					replay_drops++;
			end
			ACT_STORE: begin
				if (cfg_enable && f.ciph)
					pn_table[f.tid] = pn;
			end
			ACT_CLEAR: begin
				foreach (pn_table[i])
					pn_table[i] = '0;
			end
			default: begin
				sent_table[f.tid] &= ~slot_mask;
			end
		endcase
		v.drop = (why != REASON_NONE);
		v.reason = why;
		v.old_cnt = old_drops;
		v.replay_cnt = replay_drops;
		return v;
	endfunction

	// Build a frame; the RSC bytes outside the PN get random filler
	function automatic frame_t frame_of(action_t act, int t, int sn, logic [PN_W-1:0] pn,
			bit ciph, bit old_sn, bit old_tdls, int highest);
		frame_t f;

		f.act = act;
		f.tid = TID_W'(t);
		f.sn = SN_W'(sn);
		f.rsc = {pn[47:16], 16'($urandom), pn[15:0]};
		f.ciph = ciph;
		f.old_sn = old_sn;
		f.old_tdls = old_tdls;
		f.highest = SN_W'(highest);
		return f;
	endfunction

	// Mostly well-formed traffic around the stored PNs, with replays and noise mixed in
	function automatic frame_t random_frame(logic [SN_W-1:0] sn_base);
		frame_t          f;
		logic [PN_W-1:0] stored;
		logic [PN_W-1:0] pn;
		int              pick;

		f.tid = TID_W'($urandom_range(0, NUM_TIDS - 1));
		stored = pn_table[f.tid];
		pick = $urandom_range(0, 99);
		f.act = (pick < 80) ? ACT_CHECK : (pick < 88) ? ACT_STORE :
			(pick < 92) ? ACT_CLEAR : ACT_RELEASE;
		// Crowd most SNs into a few slots so sent-map hits and releases matter
		f.sn = ($urandom_range(0, 9) < 7) ? sn_base + SN_W'($urandom_range(0, 15)) : SN_W'($urandom);
		f.ciph = ($urandom_range(0, 9) != 0);
		f.old_tdls = ($urandom_range(0, 19) == 0);
		f.old_sn = ($urandom_range(0, 9) < 3);
		f.highest = $urandom_range(0, 1) ? SN_W'($urandom) :
			f.sn + SN_W'($urandom_range(0, 40)) - SN_W'(20);
		pick = $urandom_range(0, 99);
		if (pick < 10 || (pick < 55 && stored > PN_MAX - 5000))
			pn = PN_W'({$urandom, $urandom});
		else if (pick < 55)
			pn = stored + $urandom_range(1, 4096);
		else if (pick < 85 && stored > 200)
			pn = stored - $urandom_range(1, 100);
		else
			pn = stored;
		f.rsc = {pn[47:16], 16'($urandom), pn[15:0]};
		return f;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("ERROR verdict %0d: %s got %0h expected %0h", verdicts_seen, what, got, want);
	endtask

	// Hold the transaction on the input channel until the block takes it
	task automatic send_item(frame_t f);
		int gap;

		gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= f.act;
		tid <= f.tid;
		seq_number <= f.sn;
		key_rsc <= f.rsc;
		ciphered <= f.ciph;
		old_sn_flag <= f.old_sn;
		old_tdls_flag <= f.old_tdls;
		highest_seen_sn <= f.highest;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_verdicts.push_back(pn_filter_step(f));
	endtask

	// Drop valid and wait out every pending verdict plus the pipeline depth
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_config(logic en, logic [OPTION_W-1:0] opt);
		wait_idle();
		apb_write(ADDR_ENABLE, PDATA_W'(en));
		apb_write(ADDR_OPTION, PDATA_W'(opt));
		cfg_enable = en;
		cfg_option = opt;
	endtask

	// Reset configuration: checking off, so frames pass and stores are ignored
	task automatic test_reset_defaults();
		send_item(frame_of(ACT_CHECK, 0, 0, PN_MAX, 1, 0, 0, 0));
		send_item(frame_of(ACT_STORE, 0, 0, 48'd5, 1, 0, 0, 0));
		send_item(frame_of(ACT_RELEASE, 7, 4095, 48'd0, 0, 1, 1, 4095));
	endtask

	task automatic test_option_one();
		write_config(1'b1, OPT_ONE);
		send_item(frame_of(ACT_CHECK, 1, 10, 48'd0, 0, 0, 0, 10));
		send_item(frame_of(ACT_CHECK, 1, 10, 48'd0, 1, 0, 1, 10));
		send_item(frame_of(ACT_CHECK, 1, 10, 48'd5, 1, 1, 0, 10));
		// PN 3 passes only if the store while disabled was ignored
		send_item(frame_of(ACT_CHECK, 0, 11, 48'd3, 1, 0, 0, 11));
		send_item(frame_of(ACT_CHECK, 0, 12, 48'd3, 1, 0, 0, 12));
		send_item(frame_of(ACT_CHECK, 7, 4095, PN_MAX, 1, 0, 0, 4095));
		send_item(frame_of(ACT_CHECK, 7, 0, PN_MAX, 1, 0, 0, 0));
		send_item(frame_of(ACT_CLEAR, 2, 0, 48'd0, 0, 0, 0, 0));
		send_item(frame_of(ACT_CHECK, 7, 1, 48'd1, 1, 0, 0, 1));
	endtask

	task automatic test_option_two();
		write_config(1'b1, OPT_TWO);
		send_item(frame_of(ACT_CHECK, 3, 4095, 48'd10, 1, 0, 0, 4095));
		send_item(frame_of(ACT_CHECK, 3, 5, 48'd10, 1, 0, 0, 5));
		// Slot already sent: old or duplicate
		send_item(frame_of(ACT_CHECK, 3, 4095, 48'd1, 1, 1, 0, 4095));
		send_item(frame_of(ACT_RELEASE, 3, 4095, 48'd0, 1, 0, 0, 0));
		// SN ahead of highest: PN must rise
		send_item(frame_of(ACT_CHECK, 3, 4095, 48'd11, 1, 1, 0, 4094));
		// SN not ahead: PN must fall
		send_item(frame_of(ACT_CHECK, 3, 0, 48'd9, 1, 1, 0, 0));
		// Distance exactly half the SN space counts as not ahead
		send_item(frame_of(ACT_CHECK, 3, 1, 48'd10, 1, 1, 0, 2049));
		send_item(frame_of(ACT_CHECK, 3, 2, 48'd12, 1, 1, 0, 2051));
		send_item(frame_of(ACT_STORE, 3, 0, 48'd100, 1, 0, 0, 0));
		send_item(frame_of(ACT_STORE, 3, 0, 48'd200, 0, 0, 0, 0));
		send_item(frame_of(ACT_CHECK, 3, 7, 48'd150, 1, 0, 0, 7));
	endtask

	task automatic test_pass_options();
		write_config(1'b1, OPT_PASS_LOW);
		send_item(frame_of(ACT_CHECK, 2, 20, 48'd0, 1, 1, 0, 20));
		write_config(1'b1, OPT_PASS_HIGH);
		send_item(frame_of(ACT_CHECK, 2, 21, 48'd0, 1, 0, 0, 21));
		// Clear and release act even with checking disabled
		write_config(1'b0, OPT_TWO);
		send_item(frame_of(ACT_CLEAR, 0, 0, 48'd0, 1, 0, 0, 0));
		send_item(frame_of(ACT_RELEASE, 3, 0, 48'd0, 1, 0, 0, 0));
	endtask

	task automatic test_random_traffic();
		logic [OPTION_W-1:0] opt;
		logic [SN_W-1:0]     sn_base;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p % 5 == 3)
				opt = (p < 5) ? OPT_PASS_LOW : OPT_PASS_HIGH;
			else
				opt = (p % 2) ? OPT_ONE : OPT_TWO;
			write_config(p != 4, opt);
			case (p % 4)
				0: begin tx_gaps_on = 1; rx_gaps_on = 1; end
				1: begin tx_gaps_on = 1; rx_gaps_on = 0; end
				2: begin tx_gaps_on = 0; rx_gaps_on = 1; end
				default: begin tx_gaps_on = 0; rx_gaps_on = 0; end
			endcase
			sn_base = SN_W'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold off once mid-phase until the result side has drained
				if (p == 5 && n == PHASE_ITEMS / 2)
					wait_idle();
				send_item(random_frame(sn_base));
			end
		end
	endtask

	// Result side: when rx_gaps_on is set, drop out_ready for a random gap before each transaction
	initial begin : result_sink
		int stall;

		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : verdict_check
		verdict_t want;

		if (arst_n && out_valid && out_ready) begin
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result", {drop, drop_reason}, 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (drop !== want.drop)
					report_mismatch("drop", drop, want.drop);
				if (drop_reason !== want.reason)
					report_mismatch("drop_reason", drop_reason, want.reason);
				if (old_drop_count !== want.old_cnt)
					report_mismatch("old_drop_count", old_drop_count, want.old_cnt);
				if (replay_drop_count !== want.replay_cnt)
					report_mismatch("replay_drop_count", replay_drop_count, want.replay_cnt);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_CHECK;
		tid = '0;
		seq_number = '0;
		key_rsc = '0;
		ciphered = 1'b0;
		old_sn_flag = 1'b0;
		old_tdls_flag = 1'b0;
		highest_seen_sn = '0;
		out_ready = 1'b0;
		mismatches = 0;
		verdicts_seen = 0;
		tx_gaps_on = 1;
		rx_gaps_on = 1;
		// Predicted state after reset
		foreach (pn_table[i]) begin
			pn_table[i] = '0;
			sent_table[i] = '0;
		end
		old_drops = '0;
		replay_drops = '0;
		cfg_enable = 1'b0;
		cfg_option = OPT_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_option_one();
		test_option_two();
		test_pass_options();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("block_ack_pn_replay_check_unit regression: pass");
		else
			$display("block_ack_pn_replay_check_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
